// ===== rtl/core/rmq_pkg.sv =====
package rmq_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 30;

  // Width of the unnormalized vector, wide enough for three entries plus one.
  localparam int VW = WORD_BITS + 3;
  // Block scaling brings every magnitude below 2^LIM.
  localparam int LIM = (62 - FRAC_BITS < 31) ? (62 - FRAC_BITS) : 31;
  localparam int KMAX = (VW > LIM) ? (VW - LIM) : 0;
  localparam int KW = $clog2(KMAX + 2);
  localparam int PW = 2 * LIM;
  localparam int SW = 2 * LIM + 2;
  localparam int NW = LIM + 1;
  localparam int DW = LIM + FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 1;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW = $clog2(FQ_DEPTH);

  localparam logic signed [VW-1:0] ONE_V = VW'(1) << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1) << FRAC_BITS;

  typedef struct packed {
    logic              degen;
    logic [3:0][VW-1:0] v;
  } fr_t;

  typedef struct packed {
    logic                valid;
    logic                degen;
    logic [3:0]          neg;
    logic [3:0][LIM-1:0] mag;
  } pl_t;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [3:0] neg;
  } dl_t;

endpackage

// ===== rtl/core/rmq_front.sv =====
module rmq_front import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [9*WORD_BITS-1:0] s_axis_tdata, // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output fr_t                    fr,
  output logic                   fr_valid,
  input  logic                   fr_take
);

  logic signed [VW-1:0] a [9];
  logic signed [VW-1:0] tr;
  logic signed [VW-1:0] r;
  fr_t fr_next;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      a[i] = VW'($signed(s_axis_tdata[i*WORD_BITS +: WORD_BITS]));
    end
    tr = a[0] + a[4] + a[8];
    r = ONE_V;
    fr_next.degen = 1'b0;
    if (tr > 0) begin
      fr_next.v[0] = ONE_V + tr;
      fr_next.v[1] = a[7] - a[5];
      fr_next.v[2] = a[2] - a[6];
      fr_next.v[3] = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      r = ONE_V + a[0] - a[4] - a[8];
      fr_next.v[0] = a[7] - a[5];
      fr_next.v[1] = r;
      fr_next.v[2] = a[1] + a[3];
      fr_next.v[3] = a[2] + a[6];
    end else if (a[4] > a[8]) begin
      r = ONE_V + a[4] - a[0] - a[8];
      fr_next.v[0] = a[2] - a[6];
      fr_next.v[1] = a[1] + a[3];
      fr_next.v[2] = r;
      fr_next.v[3] = a[5] + a[7];
    end else begin
      r = ONE_V + a[8] - a[0] - a[4];
      fr_next.v[0] = a[3] - a[1];
      fr_next.v[1] = a[2] + a[6];
      fr_next.v[2] = a[5] + a[7];
      fr_next.v[3] = r;
    end
    // A diagonal branch whose radicand is not positive has no real root.
    if (r <= 0) begin
      fr_next.degen = 1'b1;
    end
  end

  assign s_axis_tready = !fr_valid || fr_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (s_axis_tready) begin
      fr_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      fr <= fr_next;
    end
  end

endmodule

// ===== rtl/core/rmq_fifo.sv =====
module rmq_fifo import rmq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  fr_t  wdata,
  output logic full,
  input  logic pop,
  output fr_t  rdata,
  output logic empty
);

  fr_t mem [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr;
  logic [FQ_AW-1:0] rd_ptr;
  logic [FQ_AW:0] count;

  assign full = (count == (FQ_AW+1)'(FQ_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/core/rmq_isqrt.sv =====
module rmq_isqrt import rmq_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [SW-1:0] x,
  output logic [NW-1:0] root
);

  // One root bit per stage, two radicand bits consumed per stage.
  logic [SW-1:0]   xs   [NW];
  logic [NW+1:0]   rs   [NW];
  logic [NW-1:0]   qs   [NW];
  logic [SW-1:0]   xn   [NW];
  logic [NW+1:0]   rn   [NW];
  logic [NW-1:0]   qn   [NW];

  always_comb begin
    logic [SW-1:0] xi;
    logic [NW+1:0] ri;
    logic [NW-1:0] qi;
    logic [NW+3:0] t;
    logic [NW+3:0] trial;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        xi = x;
        ri = '0;
        qi = '0;
      end else begin
        xi = xs[s-1];
        ri = rs[s-1];
        qi = qs[s-1];
      end
      t = {ri, xi[SW-1:SW-2]};
      trial = (NW+4)'({qi, 2'b01});
      if (t >= trial) begin
        rn[s] = (NW+2)'(t - trial);
        qn[s] = {qi[NW-2:0], 1'b1};
      end else begin
        rn[s] = (NW+2)'(t);
        qn[s] = {qi[NW-2:0], 1'b0};
      end
      xn[s] = xi << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        xs[s] <= xn[s];
        rs[s] <= rn[s];
        qs[s] <= qn[s];
      end
    end
  end

  assign root = qs[NW-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
module rmq_div import rmq_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] d,
  input  logic [NW-1:0] n,
  output logic [QW-1:0] q
);

  // The quotient never exceeds 2^FRAC_BITS, so the bits above the low QW
  // bits of the dividend already form a partial remainder below the divisor.
  logic [QW-1:0] lo  [QW];
  logic [NW:0]   rm  [QW];
  logic [NW-1:0] dv  [QW];
  logic [QW-1:0] qq  [QW];
  logic [QW-1:0] lon [QW];
  logic [NW:0]   rmn [QW];
  logic [QW-1:0] qqn [QW];

  always_comb begin
    logic [QW-1:0] li;
    logic [NW:0]   ri;
    logic [NW-1:0] ni;
    logic [QW-1:0] qi;
    logic [NW+1:0] t;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        li = d[QW-1:0];
        ri = (NW+1)'(d >> QW);
        ni = n;
        qi = '0;
      end else begin
        li = lo[s-1];
        ri = rm[s-1];
        ni = dv[s-1];
        qi = qq[s-1];
      end
      t = {ri, li[QW-1]};
      if (t >= (NW+2)'(ni)) begin
        rmn[s] = (NW+1)'(t - (NW+2)'(ni));
        qqn[s] = {qi[QW-2:0], 1'b1};
      end else begin
        rmn[s] = (NW+1)'(t);
        qqn[s] = {qi[QW-2:0], 1'b0};
      end
      lon[s] = li << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        lo[s] <= lon[s];
        rm[s] <= rmn[s];
        qq[s] <= qqn[s];
        dv[s] <= (s == 0) ? n : dv[(s == 0) ? 0 : s-1];
      end
    end
  end

  assign q = qq[QW-1];

endmodule

// ===== rtl/core/rmq_back.sv =====
module rmq_back import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  fr_t                    fr,
  input  logic                   fr_avail,
  output logic                   fr_pop,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [4*WORD_BITS-1:0] m_axis_tdata, // q_w q_x q_y q_z
  output logic [0:0]             m_axis_tuser  // degenerate
);

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign fr_pop = en && fr_avail;

  // Magnitudes, signs and block scaling.
  pl_t pa, pa_next;
  always_comb begin
    logic [VW-1:0] m [4];
    logic [VW-1:0] orv;
    logic [KW-1:0] k;
    orv = '0;
    for (int i = 0; i < 4; i++) begin
      pa_next.neg[i] = fr.v[i][VW-1];
      m[i] = fr.v[i][VW-1] ? (VW'(0) - fr.v[i]) : fr.v[i];
      orv = orv | m[i];
    end
    k = '0;
    for (int j = 1; j <= KMAX; j++) begin
      if ((orv >> (LIM + j - 1)) != '0) begin
        k = KW'(j);
      end
    end
    for (int i = 0; i < 4; i++) begin
      pa_next.mag[i] = LIM'(m[i] >> k);
    end
    pa_next.valid = fr_avail;
    pa_next.degen = fr.degen;
  end

  pl_t pb;
  logic [3:0][PW-1:0] sq;
  pl_t pc;
  logic [SW-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      pa.valid <= 1'b0;
      pb.valid <= 1'b0;
      pc.valid <= 1'b0;
    end else if (en) begin
      pa <= pa_next;
      pb <= pa;
      for (int i = 0; i < 4; i++) begin
        sq[i] <= pa.mag[i] * pa.mag[i];
      end
      pc <= pb;
      sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]) + SW'(sq[3]);
    end
  end

  logic pc_zero;
  assign pc_zero = (sum == '0);

  pl_t pc_flag;
  always_comb begin
    pc_flag = pc;
    pc_flag.degen = pc.degen || pc_zero;
  end

  logic [NW-1:0] root;
  rmq_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .x    (sum),
    .root (root)
  );

  pl_t sq_pl [NW];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NW; s++) begin
        sq_pl[s].valid <= 1'b0;
      end
    end else if (en) begin
      sq_pl[0] <= pc_flag;
      for (int s = 1; s < NW; s++) begin
        sq_pl[s] <= sq_pl[s-1];
      end
    end
  end

  // Dividends with round-to-nearest offset.
  logic [3:0][DW-1:0] dd;
  logic [NW-1:0] nd;
  dl_t pd;
  always_ff @(posedge clk) begin
    if (rst) begin
      pd.valid <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < 4; i++) begin
        dd[i] <= (DW'(sq_pl[NW-1].mag[i]) << FRAC_BITS) + DW'(root >> 1);
      end
      nd <= root;
      pd.valid <= sq_pl[NW-1].valid;
      pd.degen <= sq_pl[NW-1].degen;
      pd.neg <= sq_pl[NW-1].neg;
    end
  end

  logic [3:0][QW-1:0] qv;
  for (genvar i = 0; i < 4; i++) begin : g_lane
    rmq_div u_div (
      .clk (clk),
      .en  (en),
      .d   (dd[i]),
      .n   (nd),
      .q   (qv[i])
    );
  end

  dl_t dv_pl [QW];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < QW; s++) begin
        dv_pl[s].valid <= 1'b0;
      end
    end else if (en) begin
      dv_pl[0] <= pd;
      for (int s = 1; s < QW; s++) begin
        dv_pl[s] <= dv_pl[s-1];
      end
    end
  end

  logic [3:0][WORD_BITS-1:0] qo;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (dv_pl[QW-1].degen) begin
        qo[i] = (i == 0) ? ONE_W : '0;
      end else if (dv_pl[QW-1].neg[i]) begin
        qo[i] = WORD_BITS'(WORD_BITS'(0) - WORD_BITS'(qv[i]));
      end else begin
        qo[i] = WORD_BITS'(qv[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_pl[QW-1].valid;
    end
    if (en) begin
      m_axis_tdata <= qo;
      m_axis_tuser <= dv_pl[QW-1].degen;
    end
  end

endmodule

// ===== rtl/core/rotation_matrix_to_quaternion_top.sv =====
// Converts a 3x3 rotation matrix (nine Q2.30 entries) to the unit quaternion
// w,x,y,z in Q2.30, picking the trace or largest-diagonal branch and then
// normalizing by the integer root of the sum of squares, each quotient
// rounded to nearest. A non-positive radicand or a zero norm returns the
// identity quaternion with the degenerate flag set. A new matrix is accepted
// every clock cycle while the queue has room. Data pass a bit-per-stage
// square root pipeline (32 stages) and then four bit-per-stage dividers
// (31 stages). A four-entry queue separates the input stage from the
// normalization pipeline, which stalls as a whole while the output is held.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [9*WORD_BITS-1:0] s_axis_tdata, // m00 m01 m02 m10 m11 m12 m20 m21 m22
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [4*WORD_BITS-1:0] m_axis_tdata, // q_w q_x q_y q_z
  output logic [0:0]             m_axis_tuser  // degenerate
);

  fr_t  fr;
  fr_t  fq;
  logic fr_valid;
  logic fq_full;
  logic fq_empty;
  logic fq_pop;
  logic fr_take;

  assign fr_take = fr_valid && !fq_full;

  rmq_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .fr            (fr),
    .fr_valid      (fr_valid),
    .fr_take       (fr_take)
  );

  rmq_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_take),
    .wdata (fr),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq),
    .empty (fq_empty)
  );

  rmq_back u_back (
    .clk           (clk),
    .rst           (rst),
    .fr            (fq),
    .fr_avail      (!fq_empty),
    .fr_pop        (fq_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== tb/rotation_matrix_to_quaternion_top_test.sv =====
module rotation_matrix_to_quaternion_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  typedef struct {
    logic [WORD_BITS-1:0] q[4];
    logic                 degen;
  } quat_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [9*WORD_BITS-1:0] s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [4*WORD_BITS-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;

  logic [9*WORD_BITS-1:0] pending_mats[$];
  quat_t                  expected_quats[$];
  int                     mismatch_count;
  int                     cycle_count;
  int                     idle_mode;
  bit                     stim_done;

  rotation_matrix_to_quaternion_top i_dut (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint entry(logic [9*WORD_BITS-1:0] d, int idx);
    return longint'($signed(d[idx*WORD_BITS +: WORD_BITS]));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic quat_t matrix_to_quat(logic [9*WORD_BITS-1:0] d);
    quat_t           res;
    longint          a[9];
    longint          v[4];
    longint unsigned mag[4];
    bit              neg[4];
    longint          one;
    longint          tr;
    longint          r;
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned n;
    longint unsigned qq;
    int              k;
    one = 64'sd1 <<< FRAC_BITS;
    r = 1;
    for (int i = 0; i < 9; i++) a[i] = entry(d, i);
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      v = '{one + tr, a[7] - a[5], a[2] - a[6], a[3] - a[1]};
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      r = one + a[0] - a[4] - a[8];
      v = '{a[7] - a[5], r, a[1] + a[3], a[2] + a[6]};
    end else if (a[4] > a[8]) begin
      r = one + a[4] - a[0] - a[8];
      v = '{a[2] - a[6], a[1] + a[3], r, a[5] + a[7]};
    end else begin
      r = one + a[8] - a[0] - a[4];
      v = '{a[3] - a[1], a[2] + a[6], a[5] + a[7], r};
    end
    res.degen = (r <= 0);
    if (!res.degen) begin
      mx = 0;
      sum = 0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
        neg[i] = v[i] < 0;
        mag[i] = neg[i] ? -v[i] : v[i];
        if (mag[i] > mx) mx = mag[i];
      end
      while (k < 63 && (mx >> k) >= (64'd1 << LIM)) k++;
      for (int i = 0; i < 4; i++) begin
        mag[i] >>= k;
        sum += mag[i] * mag[i];
      end
      if (sum == 0) begin
        res.degen = 1'b1;
      end else begin
        n = int_sqrt(sum);
        for (int i = 0; i < 4; i++) begin
          qq = ((mag[i] << FRAC_BITS) + (n >> 1)) / n;
          if (neg[i]) qq = -qq;
          res.q[i] = qq[WORD_BITS-1:0];
        end
      end
    end
    if (res.degen) begin
      res.q = '{ONE_W, '0, '0, '0};
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  function automatic bit chance(int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Driver: a new transfer is offered only once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) expected_quats.push_back(matrix_to_quat(s_axis_tdata));
      if (pending_mats.size() > 0 && !(idle_mode == 0 && chance(10)) &&
          !(idle_mode == 1 && chance(55))) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_mats.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !((idle_mode == 0 && chance(55)) || (idle_mode == 1 && chance(10)));
    end
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected transfer", m_axis_tdata[WORD_BITS-1:0], '0);
      end else begin
        want = expected_quats.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_axis_tdata[i*WORD_BITS +: WORD_BITS] !== want.q[i])
            report_mismatch($sformatf("q[%0d]", i),
                            m_axis_tdata[i*WORD_BITS +: WORD_BITS], want.q[i]);
        end
        if (m_axis_tuser[0] !== want.degen)
          report_mismatch("degenerate", WORD_BITS'(m_axis_tuser),
                          WORD_BITS'(want.degen));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(5, 0))
      0: return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      1: return $urandom_range(2, 0) == 0 ? 32'h0 :
                ($urandom_range(1, 0) ? 32'h4000_0000 : 32'hc000_0000);
      default: return $urandom();
    endcase
  endfunction

  // A near-rotation: a signed permutation of the unit axes plus small noise.
  function automatic logic [9*WORD_BITS-1:0] rand_rotation();
    logic [9*WORD_BITS-1:0] d;
    int                     perm[3];
    int                     j;
    perm = '{0, 1, 2};
    perm.shuffle();
    for (int i = 0; i < 9; i++) begin
      j = $urandom_range(12, 0);
      d[i*WORD_BITS +: WORD_BITS] = $signed(j * 32'sd1000) - 32'sd6000;
    end
    for (int i = 0; i < 3; i++) begin
      j = i * 3 + perm[i];
      d[j*WORD_BITS +: WORD_BITS] = ($urandom_range(1, 0) ? 32'h4000_0000 : 32'hc000_0000)
                                    + $urandom_range(200000, 0) - 100000;
    end
    return d;
  endfunction

  function automatic logic [9*WORD_BITS-1:0] diag_mat(logic [WORD_BITS-1:0] d0,
      logic [WORD_BITS-1:0] d1, logic [WORD_BITS-1:0] d2);
    logic [9*WORD_BITS-1:0] d;
    d = '0;
    d[0 +: WORD_BITS] = d0;
    d[4*WORD_BITS +: WORD_BITS] = d1;
    d[8*WORD_BITS +: WORD_BITS] = d2;
    return d;
  endfunction

  initial begin
    logic [9*WORD_BITS-1:0] d;
    rst = 1'b1;
    idle_mode = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pending_mats.push_back(diag_mat(32'h4000_0000, 32'h4000_0000, 32'h4000_0000));
    pending_mats.push_back(diag_mat(32'h4000_0000, 32'hc000_0000, 32'hc000_0000));
    pending_mats.push_back(diag_mat(32'hc000_0000, 32'h4000_0000, 32'hc000_0000));
    pending_mats.push_back(diag_mat(32'hc000_0000, 32'hc000_0000, 32'h4000_0000));
    // Ties on the diagonal fall to later branches.
    pending_mats.push_back(diag_mat(32'hc000_0000, 32'hc000_0000, 32'hc000_0000));
    pending_mats.push_back(diag_mat(32'h0, 32'h0, 32'h0));
    // Diagonal matrices with extreme entries.
    pending_mats.push_back(diag_mat(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_mats.push_back(diag_mat(32'hc000_0000, 32'h0, 32'h0));
    pending_mats.push_back(diag_mat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    pending_mats.push_back(diag_mat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    pending_mats.push_back({9{32'h8000_0000}});
    pending_mats.push_back({9{32'h7fff_ffff}});
    pending_mats.push_back({9{32'hffff_ffff}});
    pending_mats.push_back({9{32'h5555_5555}});
    pending_mats.push_back({9{32'haaaa_aaaa}});
    for (int i = 0; i < 5; i++) pending_mats.push_back(rand_rotation());

    for (int ph = 0; ph < 3; ph++) begin
      idle_mode = ph;
      for (int i = 0; i < 330; i++) begin
        if (chance(70)) begin
          d = rand_rotation();
        end else begin
          for (int j = 0; j < 9; j++) d[j*WORD_BITS +: WORD_BITS] = rand_word();
        end
        pending_mats.push_back(d);
      end
      while (pending_mats.size() > 0) @(posedge clk);
    end
    while (s_axis_tvalid || expected_quats.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== rotation_matrix_to_quaternion_top.f =====
rtl/core/rmq_pkg.sv
rtl/core/rmq_front.sv
rtl/core/rmq_fifo.sv
rtl/core/rmq_isqrt.sv
rtl/core/rmq_div.sv
rtl/core/rmq_back.sv
rtl/core/rotation_matrix_to_quaternion_top.sv
tb/rotation_matrix_to_quaternion_top_test.sv
